>>> rtl/weight_driven_watering_controller_assert.svh
// Assertion macros for the watering controller checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef WEIGHT_DRIVEN_WATERING_CONTROLLER_ASSERT_SVH
`define WEIGHT_DRIVEN_WATERING_CONTROLLER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define WDWC_ASSERT_SAME(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("assertion label failed");

// The condition must hold in the cycle after the trigger.
`define WDWC_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("assertion label failed");

`endif

>>> rtl/wdwc_pkg.sv
package wdwc_pkg;

	// Field widths.
	localparam int COUNT_WIDTH     = 16;
	localparam int WEIGHT_WIDTH    = 20;
	localparam int TIME_WIDTH      = 32;
	localparam int OP_WIDTH        = 2;
	localparam int STATE_WIDTH     = 3;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 32;

	// Operation codes.
	localparam logic [OP_WIDTH-1:0] OP_UPDATE    = 2'd0;
	localparam logic [OP_WIDTH-1:0] OP_RESET_RUN = 2'd1;
	localparam logic [OP_WIDTH-1:0] OP_CLEAR_ERR = 2'd2;

	// Controller state codes.
	localparam logic [STATE_WIDTH-1:0] ST_IDLE     = 3'd0;
	localparam logic [STATE_WIDTH-1:0] ST_WAIT     = 3'd1;
	localparam logic [STATE_WIDTH-1:0] ST_WATER    = 3'd2;
	localparam logic [STATE_WIDTH-1:0] ST_DONE     = 3'd3;
	localparam logic [STATE_WIDTH-1:0] ST_MANUAL   = 3'd4;
	localparam logic [STATE_WIDTH-1:0] ST_ESENSOR  = 3'd5;
	localparam logic [STATE_WIDTH-1:0] ST_ETIMEOUT = 3'd6;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AUTO_MODE     = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_WEIGHT  = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TARGET_WEIGHT = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_PUMP_MS   = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COOLDOWN_MS   = 3'd4;

	// Configuration reset values.
	localparam logic [TIME_WIDTH-1:0] MAX_PUMP_MS_RESET = 32'd60000;
	localparam logic [TIME_WIDTH-1:0] COOLDOWN_MS_RESET = 32'd30000;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// Counter step that holds at the top value.
	function automatic count_t sat_inc(input count_t c);
		if (c == {COUNT_WIDTH{1'b1}}) begin
			return c;
		end
		return c + count_t'(1);
	endfunction

endpackage

>>> rtl/weight_driven_watering_controller.sv
// A request is registered in the input register, and its result in the result register.
// Throughput: one request per cycle while out_stall is low; the update of the controller
// state between the input register and the result register is combinational.
// Reset (arst_n low, asynchronous): state idle, pump off, counters and run data
// cleared, auto_mode off, weights 0, max_pump_ms 60000, cooldown_ms 30000.
module weight_driven_watering_controller (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration writes.
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [wdwc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [wdwc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
	// Input requests.
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [wdwc_pkg::OP_WIDTH-1:0]          operation,
	input  logic signed [wdwc_pkg::WEIGHT_WIDTH-1:0] weight,
	input  logic [wdwc_pkg::TIME_WIDTH-1:0]        now_ms,
	// Results.
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [wdwc_pkg::STATE_WIDTH-1:0]       pot_state,
	output logic                                   pump_on,
	output logic [wdwc_pkg::COUNT_WIDTH-1:0]       error_count,
	output logic [wdwc_pkg::COUNT_WIDTH-1:0]       watering_count,
	output logic signed [wdwc_pkg::WEIGHT_WIDTH-1:0] run_start_weight
);

	// Configuration registers.
	logic                                          auto_mode_q;
	logic signed [wdwc_pkg::WEIGHT_WIDTH-1:0]      start_weight_q;
	logic signed [wdwc_pkg::WEIGHT_WIDTH-1:0]      target_weight_q;
	logic [wdwc_pkg::TIME_WIDTH-1:0]               max_pump_ms_q;
	logic [wdwc_pkg::TIME_WIDTH-1:0]               cooldown_ms_q;

	// Input register.
	logic                                          valid_s1;
	logic [wdwc_pkg::OP_WIDTH-1:0]                 op_s1;
	logic signed [wdwc_pkg::WEIGHT_WIDTH-1:0]      weight_s1;
	logic [wdwc_pkg::TIME_WIDTH-1:0]               now_s1;

	// Controller state; it also forms the result register.
	logic [wdwc_pkg::STATE_WIDTH-1:0]              fsm_state_q;
	logic                                          pump_running_q;
	logic [wdwc_pkg::TIME_WIDTH-1:0]               run_start_time_q;
	logic signed [wdwc_pkg::WEIGHT_WIDTH-1:0]      start_weight_seen_q;
	wdwc_pkg::count_t                              errors_seen_q;
	wdwc_pkg::count_t                              runs_done_q;
	logic                                          out_valid_q;

	// Next state.
	logic [wdwc_pkg::STATE_WIDTH-1:0]              fsm_state_n;
	logic                                          pump_running_n;
	logic [wdwc_pkg::TIME_WIDTH-1:0]               run_start_time_n;
	logic signed [wdwc_pkg::WEIGHT_WIDTH-1:0]      start_weight_seen_n;
	wdwc_pkg::count_t                              errors_seen_n;
	wdwc_pkg::count_t                              runs_done_n;
	logic [wdwc_pkg::TIME_WIDTH-1:0]               elapsed;
	logic                                          advance;

	// The request in the input register moves on when the result slot is free.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q     <= 1'b0;
			start_weight_q  <= '0;
			target_weight_q <= '0;
			max_pump_ms_q   <= wdwc_pkg::MAX_PUMP_MS_RESET;
			cooldown_ms_q   <= wdwc_pkg::COOLDOWN_MS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wdwc_pkg::CFG_AUTO_MODE:     auto_mode_q     <= cfg_data[0];
				wdwc_pkg::CFG_START_WEIGHT:  start_weight_q  <= cfg_data[wdwc_pkg::WEIGHT_WIDTH-1:0];
				wdwc_pkg::CFG_TARGET_WEIGHT: target_weight_q <= cfg_data[wdwc_pkg::WEIGHT_WIDTH-1:0];
				wdwc_pkg::CFG_MAX_PUMP_MS:   max_pump_ms_q   <= cfg_data[wdwc_pkg::TIME_WIDTH-1:0];
				wdwc_pkg::CFG_COOLDOWN_MS:   cooldown_ms_q   <= cfg_data[wdwc_pkg::TIME_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1     <= operation;
			weight_s1 <= weight;
			now_s1    <= now_ms;
		end
	end

	assign elapsed = now_s1 - run_start_time_q;

	// One step of the controller for the request in the input register.
	always_comb begin
		fsm_state_n         = fsm_state_q;
		pump_running_n      = pump_running_q;
		run_start_time_n    = run_start_time_q;
		start_weight_seen_n = start_weight_seen_q;
		errors_seen_n       = errors_seen_q;
		runs_done_n         = runs_done_q;
		case (op_s1)
			wdwc_pkg::OP_UPDATE: begin
				if (weight_s1[wdwc_pkg::WEIGHT_WIDTH-1]) begin
					// Sensor failure: stop the pump and count a new error entry unless already in ESENSOR.
					if (pump_running_q) begin
						pump_running_n = 1'b0;
						runs_done_n    = wdwc_pkg::sat_inc(runs_done_q);
						fsm_state_n    = wdwc_pkg::ST_DONE;
					end
					if (fsm_state_n != wdwc_pkg::ST_ESENSOR) begin
						errors_seen_n = wdwc_pkg::sat_inc(errors_seen_q);
					end
					fsm_state_n = wdwc_pkg::ST_ESENSOR;
				end else if (!auto_mode_q) begin
					// Manual mode holds the pump off.
					if (pump_running_q) begin
						pump_running_n = 1'b0;
						runs_done_n    = wdwc_pkg::sat_inc(runs_done_q);
					end
					fsm_state_n = wdwc_pkg::ST_MANUAL;
				end else begin
					case (fsm_state_q)
						wdwc_pkg::ST_IDLE, wdwc_pkg::ST_MANUAL: begin
							fsm_state_n = wdwc_pkg::ST_WAIT;
						end
						wdwc_pkg::ST_WAIT: begin
							// A pump that is already running keeps its run data.
							if (weight_s1 < start_weight_q && !pump_running_q) begin
								pump_running_n      = 1'b1;
								run_start_time_n    = now_s1;
								start_weight_seen_n = weight_s1;
								fsm_state_n         = wdwc_pkg::ST_WATER;
							end
						end
						wdwc_pkg::ST_WATER: begin
							if (weight_s1 >= target_weight_q) begin
								if (pump_running_q) begin
									pump_running_n = 1'b0;
									runs_done_n    = wdwc_pkg::sat_inc(runs_done_q);
									fsm_state_n    = wdwc_pkg::ST_DONE;
								end
							end else if (elapsed > max_pump_ms_q) begin
								// Run timeout: always a fresh error entry.
								if (pump_running_q) begin
									pump_running_n = 1'b0;
									runs_done_n    = wdwc_pkg::sat_inc(runs_done_q);
								end
								errors_seen_n = wdwc_pkg::sat_inc(errors_seen_q);
								fsm_state_n   = wdwc_pkg::ST_ETIMEOUT;
							end
						end
						wdwc_pkg::ST_DONE: begin
							if (pump_running_q) begin
								pump_running_n = 1'b0;
								runs_done_n    = wdwc_pkg::sat_inc(runs_done_q);
							end
							fsm_state_n = wdwc_pkg::ST_WAIT;
						end
						wdwc_pkg::ST_ESENSOR: begin
							if (pump_running_q) begin
								pump_running_n = 1'b0;
								runs_done_n    = wdwc_pkg::sat_inc(runs_done_q);
								fsm_state_n    = wdwc_pkg::ST_DONE;
							end
							// The weight is known to be non-negative here.
							fsm_state_n = wdwc_pkg::ST_WAIT;
						end
						wdwc_pkg::ST_ETIMEOUT: begin
							if (pump_running_q) begin
								pump_running_n = 1'b0;
								runs_done_n    = wdwc_pkg::sat_inc(runs_done_q);
								fsm_state_n    = wdwc_pkg::ST_DONE;
							end
							if (elapsed > cooldown_ms_q) begin
								fsm_state_n = wdwc_pkg::ST_WAIT;
							end
						end
						default: ;
					endcase
				end
			end
			wdwc_pkg::OP_RESET_RUN: begin
				// Restart the run bookkeeping and clear the error count; the pump is left as it is.
				fsm_state_n         = wdwc_pkg::ST_WAIT;
				errors_seen_n       = '0;
				run_start_time_n    = now_s1;
				start_weight_seen_n = weight_s1;
			end
			wdwc_pkg::OP_CLEAR_ERR: begin
				errors_seen_n = '0;
			end
			default: ;
		endcase
	end

	// Controller state update and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_state_q         <= wdwc_pkg::ST_IDLE;
			pump_running_q      <= 1'b0;
			run_start_time_q    <= '0;
			start_weight_seen_q <= '0;
			errors_seen_q       <= '0;
			runs_done_q         <= '0;
			out_valid_q         <= 1'b0;
		end else begin
			if (advance) begin
				fsm_state_q         <= fsm_state_n;
				pump_running_q      <= pump_running_n;
				run_start_time_q    <= run_start_time_n;
				start_weight_seen_q <= start_weight_seen_n;
				errors_seen_q       <= errors_seen_n;
				runs_done_q         <= runs_done_n;
				out_valid_q         <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign pot_state        = fsm_state_q;
	assign pump_on          = pump_running_q;
	assign error_count      = errors_seen_q;
	assign watering_count   = runs_done_q;
	assign run_start_weight = start_weight_seen_q;

endmodule

>>> rtl/wdwc_checker.sv
`include "weight_driven_watering_controller_assert.svh"

module wdwc_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic [wdwc_pkg::STATE_WIDTH-1:0]       pot_state,
	input logic                                   pump_on,
	input logic [wdwc_pkg::COUNT_WIDTH-1:0]       error_count,
	input logic [wdwc_pkg::COUNT_WIDTH-1:0]       watering_count,
	input logic signed [wdwc_pkg::WEIGHT_WIDTH-1:0] run_start_weight
);

	// A running pump is only ever reported while waiting or watering.
	`WDWC_ASSERT_SAME(a_pump_state, out_valid && pump_on, pot_state == wdwc_pkg::ST_WATER || pot_state == wdwc_pkg::ST_WAIT)

	// The watering state always drives the pump.
	`WDWC_ASSERT_SAME(a_water_pump, out_valid && pot_state == wdwc_pkg::ST_WATER, pump_on)

	// A stalled result holds all of its fields.
	`WDWC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pot_state) && $stable(pump_on) && $stable(error_count) && $stable(watering_count) && $stable(run_start_weight))

	// The counters only move together with a new result.
	`WDWC_ASSERT_SAME(a_runs_quiet, !$stable(watering_count) || !$stable(error_count), out_valid)

endmodule

bind weight_driven_watering_controller wdwc_checker u_wdwc_checker (.*);
